[design/xxh_pkg.sv]
// ----------------------------------------------------------------------------
// xxh_pkg: shared types, constants and helpers for the XXH64 stream hasher
// Holds the five XXH64 primes, the lane start values, the word type, the
// sequencer state encoding and a rotate helper.
// ----------------------------------------------------------------------------
package xxh_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = WORD_W / 2;

  typedef logic [WORD_W-1:0] word_t;

  // XXH64 primes
  localparam word_t P1 = 64'h9E37_79B1_85EB_CA87;
  localparam word_t P2 = 64'hC2B2_AE3D_27D4_EB4F;
  localparam word_t P3 = 64'h1656_67B1_9E37_79F9;
  localparam word_t P4 = 64'h85EB_CA77_C2B2_AE63;
  localparam word_t P5 = 64'h27D4_EB2F_1656_67C5;

  // lane start values (mod 2^64)
  localparam word_t LANE0_INIT = P1 + P2;
  localparam word_t LANE1_INIT = P2;
  localparam word_t LANE2_INIT = '0;
  localparam word_t LANE3_INIT = word_t'(0) - P1;

  // sequencer states, one-hot
  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_ABSORB = 11'b000_0000_0010,
    S_MERGE  = 11'b000_0000_0100,
    S_SUM    = 11'b000_0000_1000,
    S_FOLD   = 11'b000_0001_0000,
    S_LEN    = 11'b000_0010_0000,
    S_WORD   = 11'b000_0100_0000,
    S_HALF   = 11'b000_1000_0000,
    S_BYTE   = 11'b001_0000_0000,
    S_AVAL   = 11'b010_0000_0000,
    S_EMIT   = 11'b100_0000_0000
  } state_t;

  // rotate left by a constant amount
  function automatic word_t rotl(input word_t v, input int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

endpackage

[design/xxh_mul.sv]
// ----------------------------------------------------------------------------
// xxh_mul: iterative 64x64 multiplier, low 64 bits of the product
// One 32x32 multiplier is used three times (lo*lo, lo*hi, hi*lo); each
// partial product is registered before it is added. Done pulses for one
// cycle once the product is complete, with the product held on p.
// ----------------------------------------------------------------------------
module xxh_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  xxh_pkg::word_t a,
  input  xxh_pkg::word_t b,
  output logic           busy,
  output logic           done,
  output xxh_pkg::word_t p
);
  import xxh_pkg::*;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  word_t             a_r, a_nxt;
  word_t             b_r, b_nxt;
  word_t             pp_r, pp_nxt;
  word_t             acc_r, acc_nxt;
  logic [HALF_W-1:0] ma, mb;

  // operand halves for the current partial product
  always_comb begin
    unique case (cnt_r)
      2'd0: begin
        ma = a_r[HALF_W-1:0];
        mb = b_r[HALF_W-1:0];
      end
      2'd1: begin
        ma = a_r[HALF_W-1:0];
        mb = b_r[WORD_W-1:HALF_W];
      end
      2'd2: begin
        ma = a_r[WORD_W-1:HALF_W];
        mb = b_r[HALF_W-1:0];
      end
      2'd3: begin
        ma = a_r[WORD_W-1:HALF_W];
        mb = b_r[HALF_W-1:0];
      end
    endcase
  end

  // step control and accumulation
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    pp_nxt   = word_t'(ma) * word_t'(mb);
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      cnt_nxt  = 2'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 2'd1;
      unique case (cnt_r)
        2'd0: acc_nxt = acc_r;
        2'd1: acc_nxt = pp_r;
        2'd2: acc_nxt = acc_r + {pp_r[HALF_W-1:0], {HALF_W{1'b0}}};
        2'd3: begin
          acc_nxt  = acc_r + {pp_r[HALF_W-1:0], {HALF_W{1'b0}}};
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    pp_r  <= pp_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign p    = acc_r;

endmodule

[design/xxh64_stream_hash.sv]
// Work: a non-final word that does not complete a stripe is only buffered; a word that
//   completes a 32-byte stripe takes 8 multiplies.
// The last word takes a fold (a four-lane sum + 12 multiplies if 32+ bytes were
//   seen), 3 multiplies per tail word, 2 per 4-byte or single-byte round and
//   2 for the avalanche; all of them go through the shared 64-bit multiplier.
// Reset (synchronous, active low) returns lanes, length and counts to start.
// ----------------------------------------------------------------------------
// xxh64_stream_hash: XXH64 (seed zero) over a stream of 64-bit words
// Sequencer over one shared iterative multiplier. Keeps four lanes, three
// buffered words and the byte length; emits one digest per message through
// an output register.
// ----------------------------------------------------------------------------
module xxh64_stream_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] data_word, [67:64] valid_bytes, rest zero
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [63:0] digest
);
  import xxh_pkg::*;

  state_t     state_r, state_nxt;
  logic [1:0] sub_r, sub_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [3:0] k_r, k_nxt;
  logic [3:0] nb_r, nb_nxt;
  logic       last_r, last_nxt;
  logic       wait_r, wait_nxt;
  logic [1:0] pcnt_r, pcnt_nxt;
  word_t      total_r, total_nxt;
  word_t      lane_r [4];
  word_t      lane_nxt [4];
  word_t      pend_r [3];
  word_t      pend_nxt [3];
  word_t      w_r, w_nxt;
  word_t      t_r, t_nxt;
  word_t      h_r, h_nxt;
  word_t      out_data_r, out_data_nxt;
  logic       out_valid_r, out_valid_nxt;

  logic       in_fire;
  word_t      in_word;
  logic [3:0] in_nb;
  logic [3:0] nb_clip;
  logic       mul_start, mul_busy, mul_done;
  word_t      mul_a, mul_b, mul_p;
  word_t      word_src, lane_sel, sum_term;
  logic [7:0] byte_sel;
  logic       mul_state;

  assign in_word = in_tdata[63:0];
  assign in_nb   = in_tdata[67:64];
  assign nb_clip = (in_nb > 4'd8) ? 4'd8 : in_nb;
  assign in_tready = state_r == S_IDLE;
  assign in_fire   = in_tvalid && in_tready;

  // next step after the tail stage at word index j
  function automatic state_t tail_state(input logic [1:0] j, input logic [1:0] pc,
                                        input logic [3:0] nb);
    state_t s;
    if (j < pc)            s = S_WORD;
    else if (nb == 4'd8)   s = S_WORD;
    else if (nb >= 4'd4)   s = S_HALF;
    else if (nb != 4'd0)   s = S_BYTE;
    else                   s = S_AVAL;
    return s;
  endfunction

  // operand selection
  always_comb begin
    word_src = w_r;
    if (idx_r < pcnt_r) begin
      unique case (idx_r)
        2'd0:    word_src = pend_r[0];
        2'd1:    word_src = pend_r[1];
        2'd2:    word_src = pend_r[2];
        default: word_src = w_r;
      endcase
    end
    lane_sel = lane_r[idx_r];
    byte_sel = w_r[{k_r[2:0], 3'b000} +: 8];
    unique case (idx_r)
      2'd0: sum_term = rotl(lane_sel, 1);
      2'd1: sum_term = rotl(lane_sel, 7);
      2'd2: sum_term = rotl(lane_sel, 12);
      2'd3: sum_term = rotl(lane_sel, 18);
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    sub_nxt       = sub_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    nb_nxt        = nb_r;
    last_nxt      = last_r;
    wait_nxt      = wait_r;
    pcnt_nxt      = pcnt_r;
    total_nxt     = total_r;
    lane_nxt      = lane_r;
    pend_nxt      = pend_r;
    w_nxt         = w_r;
    t_nxt         = t_r;
    h_nxt         = h_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_start     = 1'b0;
    mul_a         = '0;
    mul_b         = P1;
    mul_state     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          w_nxt = in_word;
          if (in_tlast) begin
            last_nxt  = 1'b1;
            total_nxt = total_r + word_t'(nb_clip);
            if (nb_clip == 4'd8 && pcnt_r == 2'd3) begin
              nb_nxt    = 4'd0;
              idx_nxt   = 2'd0;
              sub_nxt   = 2'd0;
              state_nxt = S_ABSORB;
            end else begin
              nb_nxt    = nb_clip;
              state_nxt = S_MERGE;
            end
          end else begin
            last_nxt  = 1'b0;
            total_nxt = total_r + word_t'(8);
            if (pcnt_r == 2'd3) begin
              idx_nxt   = 2'd0;
              sub_nxt   = 2'd0;
              state_nxt = S_ABSORB;
            end else begin
              for (int i = 0; i < 3; i++) begin
                if (pcnt_r == 2'(i)) pend_nxt[i] = in_word;
              end
              pcnt_nxt = pcnt_r + 2'd1;
            end
          end
        end
      end

      // one lane round per lane: t = w*P2; lane = rotl(lane+t,31)*P1
      S_ABSORB: begin
        mul_state = 1'b1;
        mul_a = (sub_r == 2'd0) ? word_src : rotl(lane_sel + t_r, 31);
        mul_b = (sub_r == 2'd0) ? P2 : P1;
        if (mul_done) begin
          wait_nxt = 1'b0;
          if (sub_r == 2'd0) begin
            t_nxt   = mul_p;
            sub_nxt = 2'd1;
          end else begin
            lane_nxt[idx_r] = mul_p;
            sub_nxt = 2'd0;
            if (idx_r == 2'd3) begin
              idx_nxt   = 2'd0;
              pcnt_nxt  = 2'd0;
              state_nxt = last_r ? S_MERGE : S_IDLE;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end
      end

      // pick the start value of the final hash
      S_MERGE: begin
        idx_nxt = 2'd0;
        sub_nxt = 2'd0;
        if (|total_r[WORD_W-1:5]) begin
          state_nxt = S_SUM;
        end else begin
          h_nxt     = P5;
          state_nxt = S_LEN;
        end
      end

      // sum of rotated lanes, one lane a cycle
      S_SUM: begin
        h_nxt = ((idx_r == 2'd0) ? word_t'(0) : h_r) + sum_term;
        if (idx_r == 2'd3) begin
          idx_nxt   = 2'd0;
          state_nxt = S_FOLD;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end

      // h = (h ^ round(0, lane)) * P1 + P4
      S_FOLD: begin
        mul_state = 1'b1;
        unique case (sub_r)
          2'd0: begin
            mul_a = lane_sel;
            mul_b = P2;
          end
          2'd1: begin
            mul_a = rotl(t_r, 31);
            mul_b = P1;
          end
          default: begin
            mul_a = h_r ^ t_r;
            mul_b = P1;
          end
        endcase
        if (mul_done) begin
          wait_nxt = 1'b0;
          if (sub_r != 2'd2) begin
            t_nxt   = mul_p;
            sub_nxt = sub_r + 2'd1;
          end else begin
            h_nxt   = mul_p + P4;
            sub_nxt = 2'd0;
            if (idx_r == 2'd3) begin
              idx_nxt   = 2'd0;
              state_nxt = S_LEN;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end
      end

      // add the byte length, then start the tail
      S_LEN: begin
        h_nxt     = h_r + total_r;
        idx_nxt   = 2'd0;
        sub_nxt   = 2'd0;
        k_nxt     = 4'd0;
        state_nxt = tail_state(2'd0, pcnt_r, nb_r);
      end

      // 8-byte tail round: h = rotl(h ^ round(0, w), 27) * P1 + P4
      S_WORD: begin
        mul_state = 1'b1;
        unique case (sub_r)
          2'd0: begin
            mul_a = word_src;
            mul_b = P2;
          end
          2'd1: begin
            mul_a = rotl(t_r, 31);
            mul_b = P1;
          end
          default: begin
            mul_a = rotl(h_r ^ t_r, 27);
            mul_b = P1;
          end
        endcase
        if (mul_done) begin
          wait_nxt = 1'b0;
          if (sub_r != 2'd2) begin
            t_nxt   = mul_p;
            sub_nxt = sub_r + 2'd1;
          end else begin
            h_nxt   = mul_p + P4;
            sub_nxt = 2'd0;
            if (idx_r < pcnt_r) begin
              idx_nxt   = idx_r + 2'd1;
              state_nxt = tail_state(idx_r + 2'd1, pcnt_r, nb_r);
            end else begin
              state_nxt = S_AVAL;
            end
          end
        end
      end

      // 4-byte tail round: h = rotl(h ^ lo32*P1, 23) * P2 + P3
      S_HALF: begin
        mul_state = 1'b1;
        mul_a = (sub_r == 2'd0) ? {{HALF_W{1'b0}}, w_r[HALF_W-1:0]} : rotl(h_r ^ t_r, 23);
        mul_b = (sub_r == 2'd0) ? P1 : P2;
        if (mul_done) begin
          wait_nxt = 1'b0;
          if (sub_r == 2'd0) begin
            t_nxt   = mul_p;
            sub_nxt = 2'd1;
          end else begin
            h_nxt     = mul_p + P3;
            sub_nxt   = 2'd0;
            k_nxt     = 4'd4;
            state_nxt = (nb_r > 4'd4) ? S_BYTE : S_AVAL;
          end
        end
      end

      // single-byte tail round: h = rotl(h ^ b*P5, 11) * P1
      S_BYTE: begin
        mul_state = 1'b1;
        mul_a = (sub_r == 2'd0) ? word_t'(byte_sel) : rotl(h_r ^ t_r, 11);
        mul_b = (sub_r == 2'd0) ? P5 : P1;
        if (mul_done) begin
          wait_nxt = 1'b0;
          if (sub_r == 2'd0) begin
            t_nxt   = mul_p;
            sub_nxt = 2'd1;
          end else begin
            h_nxt   = mul_p;
            sub_nxt = 2'd0;
            k_nxt   = k_r + 4'd1;
            if (k_r + 4'd1 >= nb_r) state_nxt = S_AVAL;
          end
        end
      end

      // avalanche
      S_AVAL: begin
        mul_state = 1'b1;
        mul_a = (sub_r == 2'd0) ? (h_r ^ (h_r >> 33)) : (h_r ^ (h_r >> 29));
        mul_b = (sub_r == 2'd0) ? P2 : P3;
        if (mul_done) begin
          wait_nxt = 1'b0;
          if (sub_r == 2'd0) begin
            h_nxt   = mul_p;
            sub_nxt = 2'd1;
          end else begin
            h_nxt     = mul_p ^ (mul_p >> 32);
            sub_nxt   = 2'd0;
            state_nxt = S_EMIT;
          end
        end
      end

      // hand the digest to the output register and restart
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = h_r;
          out_valid_nxt = 1'b1;
          lane_nxt[0]   = LANE0_INIT;
          lane_nxt[1]   = LANE1_INIT;
          lane_nxt[2]   = LANE2_INIT;
          lane_nxt[3]   = LANE3_INIT;
          pcnt_nxt      = 2'd0;
          total_nxt     = '0;
          idx_nxt       = 2'd0;
          sub_nxt       = 2'd0;
          last_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // issue a multiply when a multiply step is not yet in flight
    if (mul_state && !wait_r) begin
      mul_start = 1'b1;
      wait_nxt  = 1'b1;
    end
  end

  xxh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .p     (mul_p)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sub_r       <= 2'd0;
      idx_r       <= 2'd0;
      k_r         <= 4'd0;
      nb_r        <= 4'd0;
      last_r      <= 1'b0;
      wait_r      <= 1'b0;
      pcnt_r      <= 2'd0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
      lane_r[0]   <= LANE0_INIT;
      lane_r[1]   <= LANE1_INIT;
      lane_r[2]   <= LANE2_INIT;
      lane_r[3]   <= LANE3_INIT;
    end else begin
      state_r     <= state_nxt;
      sub_r       <= sub_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      nb_r        <= nb_nxt;
      last_r      <= last_nxt;
      wait_r      <= wait_nxt;
      pcnt_r      <= pcnt_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      lane_r      <= lane_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    w_r        <= w_nxt;
    t_r        <= t_nxt;
    h_r        <= h_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a multiply finishes only while the sequencer waits on it
  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> wait_r)
    else $error("multiplier done without a pending request");

  // no multiply in flight while the block takes input
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!wait_r && !mul_busy))
    else $error("multiplier active in idle");

  // emit loads the output register and returns to idle
  a_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_tready)) |=>
      (out_valid_r && state_r == S_IDLE && pcnt_r == 2'd0))
    else $error("digest not delivered from emit");

  // a buffered word bumps the pending count
  a_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !in_tlast && pcnt_r != 2'd3) |=> (pcnt_r == $past(pcnt_r) + 2'd1))
    else $error("pending count did not advance");

endmodule

[bench/xxh64_digest_check.sv]
// ----------------------------------------------------------------------------
// xxh64_digest_check: digest predictor and comparator for xxh64_stream_hash
// Watches both stream channels. Every accepted input word goes through a
// behavioral XXH64 (seed zero); each last word queues one expected digest.
// Every output transfer is compared with the oldest queued digest.
// ----------------------------------------------------------------------------
module xxh64_digest_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,   // [63:0] data_word, [67:64] valid_bytes, rest zero
  input  logic        in_tlast,   // last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,  // [63:0] digest
  output int unsigned mismatches,
  output int unsigned awaited,
  output int unsigned digests_seen
);
  import xxh_pkg::*;

  // behavioral hash state
  word_t       lane [4];
  word_t       held [3];
  int unsigned held_n;
  word_t       msg_len;

  // digests predicted but not yet seen on the output
  word_t       digest_q [$];

  int unsigned bad_cnt = 0;
  int unsigned seen_cnt = 0;
  bit          emits;
  word_t       next_digest;
  word_t       want;

  function automatic word_t rol64(input word_t v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic word_t mix_round(input word_t acc, input word_t w);
    return rol64(acc + w * P2, 31) * P1;
  endfunction

  function automatic word_t merge_lane(input word_t h, input word_t v);
    return (h ^ mix_round('0, v)) * P1 + P4;
  endfunction

  function automatic word_t tail_round(input word_t h, input word_t w);
    return rol64(h ^ mix_round('0, w), 27) * P1 + P4;
  endfunction

  task automatic restart_hash();
    lane[0] = P1 + P2;
    lane[1] = P2;
    lane[2] = '0;
    lane[3] = word_t'(0) - P1;
    held_n  = 0;
    msg_len = '0;
  endtask

  // fold three held words plus the current one into the lanes
  task automatic absorb_stripe(input word_t fourth);
    lane[0] = mix_round(lane[0], held[0]);
    lane[1] = mix_round(lane[1], held[1]);
    lane[2] = mix_round(lane[2], held[2]);
    lane[3] = mix_round(lane[3], fourth);
    held_n  = 0;
  endtask

  // one accepted word; on a last word returns the finished digest
  task automatic hash_word(input word_t w, input logic [3:0] vb, input logic lst,
                           output bit done, output word_t d);
    word_t       h;
    int unsigned nb;
    int unsigned k;
    done = 1'b0;
    d    = '0;
    if (!lst) begin
      msg_len += 8;
      if (held_n >= 3) begin
        absorb_stripe(w);
      end else begin
        held[held_n] = w;
        held_n++;
      end
    end else begin
      nb = (vb > 4'd8) ? 8 : vb;
      msg_len += nb;
      // a full last word that closes a stripe leaves an empty tail
      if (nb == 8 && held_n >= 3) begin
        absorb_stripe(w);
        nb = 0;
      end
      if (msg_len >= 32) begin
        h = rol64(lane[0], 1) + rol64(lane[1], 7) + rol64(lane[2], 12) +
            rol64(lane[3], 18);
        for (int i = 0; i < 4; i++) h = merge_lane(h, lane[i]);
      end else begin
        h = P5;
      end
      h += msg_len;
      for (int i = 0; i < held_n; i++) h = tail_round(h, held[i]);
      // tail: 8-byte, 4-byte, then single-byte rounds
      k = 0;
      if (nb == 8) begin
        h = tail_round(h, w);
        k = 8;
      end else if (nb >= 4) begin
        h ^= (w & 64'hFFFF_FFFF) * P1;
        h = rol64(h, 23) * P2 + P3;
        k = 4;
      end
      while (k < nb) begin
        h ^= ((w >> (8 * k)) & 64'hFF) * P5;
        h = rol64(h, 11) * P1;
        k++;
      end
      // avalanche
      h ^= h >> 33;
      h *= P2;
      h ^= h >> 29;
      h *= P3;
      h ^= h >> 32;
      d    = h;
      done = 1'b1;
      restart_hash();
    end
  endtask

  // output side first: a digest leaving now belongs to an earlier message
  always @(posedge clk) begin
    if (!rst_n) begin
      restart_hash();
      digest_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen_cnt++;
        if (digest_q.size() == 0) begin
          if (bad_cnt < 10) $display("unexpected digest %h", out_tdata);
          bad_cnt++;
        end else begin
          want = digest_q.pop_front();
          if (out_tdata !== want) begin
            if (bad_cnt < 10)
              $display("digest mismatch: expected %h, got %h", want, out_tdata);
            bad_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        hash_word(in_tdata[63:0], in_tdata[67:64], in_tlast, emits, next_digest);
        if (emits) digest_q.insert(digest_q.size(), next_digest);
      end
    end
    mismatches   <= bad_cnt;
    awaited      <= digest_q.size();
    digests_seen <= seen_cnt;
  end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for xxh64_stream_hash
// Sends hand-picked messages (empty, short tails, oversized byte counts,
// stripe-aligned endings) and then random messages of mixed length, with
// random idling on both channels, one long output stall and one drain pause.
// Checking is done by xxh64_digest_check.
// ----------------------------------------------------------------------------
module tb;
  import xxh_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // [63:0] data_word, [67:64] valid_bytes, rest zero
  logic        in_tlast;   // last
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;  // [63:0] digest

  int unsigned mismatches;
  int unsigned awaited;
  int unsigned digests_seen;
  int unsigned words_sent;
  int unsigned msgs_sent;
  bit          gaps_on;
  bit          drained;

  xxh64_stream_hash uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  xxh64_digest_check checker_i (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tlast     (in_tlast),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .mismatches   (mismatches),
    .awaited      (awaited),
    .digests_seen (digests_seen)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial begin
    #30_000_000;
    $display("tb: errors");
    $finish;
  end

  // mostly random words, now and then all zeros or all ones
  function automatic word_t rand_word();
    int unsigned pick;
    pick = $urandom_range(15, 0);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  // one input transfer, preceded by an optional idle gap
  task automatic send_word(input word_t w, input logic [3:0] vb, input logic lst);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(10, 0) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'h0, vb, w};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (lst) msgs_sent++;
  endtask

  // n full words, then a last word with the given byte count
  task automatic send_msg(input int unsigned n, input logic [3:0] vb_last);
    for (int i = 0; i < n; i++) send_word(rand_word(), 4'($urandom_range(15, 0)), 1'b0);
    send_word(rand_word(), vb_last, 1'b1);
  endtask

  // receiver: random stall per transfer, one long hold-off
  initial begin
    int unsigned wait_n;
    int unsigned taken;
    bit          long_done;
    taken     = 0;
    long_done = 0;
    out_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!long_done && taken >= 40) begin
        wait_n    = 400;
        long_done = 1;
      end else if ($urandom_range(3, 0) == 0) begin
        wait_n = 0;
      end else begin
        wait_n = $urandom_range(10, 0);
      end
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      taken++;
    end
  end

  // stimulus and verdict
  initial begin
    int unsigned len_pick;
    int unsigned n_words;
    logic [3:0]  vb_last;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    words_sent = 0;
    msgs_sent  = 0;
    drained    = 0;
    gaps_on    = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed messages
    send_word(rand_word(), 4'd0, 1'b1);            // empty message
    send_word('1, 4'd3, 1'b1);                     // short tail, high bytes ignored
    send_word('0, 4'd15, 1'b1);                    // oversized byte count
    repeat (3) send_word(rand_word(), 4'd8, 1'b0); // last word closes a stripe
    send_word(rand_word(), 4'd8, 1'b1);
    repeat (4) send_word(rand_word(), 4'd2, 1'b0); // exactly 32 bytes, empty tail
    send_word(rand_word(), 4'd0, 1'b1);
    repeat (3) send_word('1, 4'd0, 1'b0);          // 28 bytes: no fold, 4-byte round
    send_word(rand_word(), 4'd4, 1'b1);
    send_word('1, 4'd9, 1'b0);                     // oversized count on last word
    send_word('1, 4'd12, 1'b1);
    repeat (7) send_word(rand_word(), 4'd8, 1'b0); // two stripes, full ending
    send_word(rand_word(), 4'd8, 1'b1);

    // random messages, mostly short
    while (words_sent < 1600) begin
      gaps_on  = ($urandom_range(3, 0) != 0);
      len_pick = $urandom_range(99, 0);
      if (len_pick < 70)      n_words = $urandom_range(7, 0);
      else if (len_pick < 95) n_words = $urandom_range(16, 8);
      else                    n_words = $urandom_range(40, 17);
      vb_last = ($urandom_range(1, 0) == 0) ? 4'd8 : 4'($urandom_range(15, 0));
      send_msg(n_words, vb_last);
      // once: let every digest drain before going on
      if (!drained && msgs_sent >= 120) begin
        drained = 1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited != 0) @(posedge clk);
      end
    end

    // wait out the last digests, then a margin for stray output
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    $display("ran %0d messages, %0d words; %0d digests compared, %0d mismatches",
             msgs_sent, words_sent, digests_seen, mismatches);
    if (awaited != 0) $display("%0d digests never arrived", awaited);
    if (mismatches == 0 && awaited == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
